// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; the empty forms stand in when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pth_pkg.sv =====
// Package for the pixel-to-hex-cell block: widths, constants, payload types.
// No dependencies; every RTL module of the block imports it.
package pth_pkg;

    // Fixed-point precision of the fractional axial coordinates.
    localparam int FRAC_BITS = 16;

    localparam int PIX_W   = 16;
    localparam int OUT_W   = 16;
    localparam int RECIP_W = 16;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd1928;

    // Scaled pixel: 16-bit signed times 0.16 unsigned, exact in Q.16.
    localparam int SCALE_W = 32;

    // Q.30 constants, held as positive signed values.
    localparam int K_FRAC = 30;
    localparam int K_W    = 31;
    localparam logic signed [K_W-1:0] K_TWO_THIRDS  = 31'sd715827883;
    localparam logic signed [K_W-1:0] K_ONE_THIRD   = 31'sd357913941;
    localparam logic signed [K_W-1:0] K_ROOT3_THIRD = 31'sd619925131;

    localparam int PROD_W    = SCALE_W + K_W - 1;
    localparam int DIFF_W    = PROD_W + 1;
    localparam int PROD_FRAC = RECIP_W + K_FRAC;
    localparam int RED_SHIFT = PROD_FRAC - FRAC_BITS;
    localparam logic signed [DIFF_W-1:0] RED_HALF =
        {{(DIFF_W-1){1'b0}}, 1'b1} << (RED_SHIFT - 1);

    // Rounded cube coordinates and fractional values.
    localparam int INT_W = 18;
    localparam int FW    = FRAC_BITS + INT_W - 1;
    localparam int EW    = FW + 1;
    localparam logic [FW-1:0] RND_HALF = FW'(1) << (FRAC_BITS - 1);

    // Offset row before saturation.
    localparam int ROW_W = INT_W + 1;
    localparam logic signed [ROW_W-1:0] SAT_HI = ROW_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ROW_W-1:0] SAT_LO = -SAT_HI - 1;

    // Configuration port.
    localparam int ADDR_W    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_RECIP = '0;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] axial_q;
        logic signed [OUT_W-1:0] axial_r;
        logic signed [OUT_W-1:0] offset_col;
        logic signed [OUT_W-1:0] offset_row;
    } hex_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] pq;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
    } prod_t;

    typedef struct packed {
        logic signed [FW-1:0] fq;
        logic signed [FW-1:0] fr;
        logic signed [FW-1:0] fs;
    } frac_t;

    typedef struct packed {
        logic signed [INT_W-1:0] q;
        logic signed [INT_W-1:0] r;
        logic signed [INT_W-1:0] s;
        logic [FRAC_BITS-1:0]    dq;
        logic [FRAC_BITS-1:0]    dr;
        logic [FRAC_BITS-1:0]    ds;
    } cube_t;

endpackage

// ===== rtl/pixel_to_hex_cell_unit.sv =====
// Throughput: one transfer per cycle; the seven-stage pipeline holds up to
// seven items, and a stall on m_ready fills empty stages before it backs up.
// Reset (aresetn low, synchronous): clears every stage valid bit and loads
// size_recip with 1928; no clearing pass, the block is ready next cycle.
// Depends on pth_pkg, pth_cfg, pth_mult, pth_frac, pth_round, pth_pick.
`include "assert_macros.svh"

module pixel_to_hex_cell_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    // pixel input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pth_pkg::pixel_t            s_data,
    // hex cell result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output pth_pkg::hex_t              m_data,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pth_pkg::ADDR_W-1:0] paddr,
    input  logic [pth_pkg::APB_DW-1:0] pwdata,
    output logic [pth_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pth_pkg::*;

    logic [RECIP_W-1:0]      size_recip;

    logic                    prod_valid;
    logic                    prod_ready;
    prod_t                   prod_data;
    logic                    frac_valid;
    logic                    frac_ready;
    frac_t                   frac_data;
    logic                    cube_valid;
    logic                    cube_ready;
    cube_t                   cube_data;
    logic signed [INT_W+1:0] cube_sum;

    // Register file. Writes must land only while the pipeline is idle, so that stage
    // one can read size_recip directly; the block itself does not enforce this.
    pth_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .size_recip (size_recip)
    );

    // Stages 1-2: scale by the reciprocal, then multiply by the Q.30
    // constants of the pixel-to-axial transform.
    pth_mult u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .size_recip (size_recip),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_data    (s_data),
        .out_valid  (prod_valid),
        .out_ready  (prod_ready),
        .out_data   (prod_data)
    );

    // Stages 3-4: drop to Q.FRAC_BITS, round half up; derive s = -q - r.
    pth_frac u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .out_data  (frac_data)
    );

    // Stages 5-6: cube rounding with halves away from zero, then the
    // absolute rounding error of each component.
    pth_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .in_data   (frac_data),
        .out_valid (cube_valid),
        .out_ready (cube_ready),
        .out_data  (cube_data)
    );

    // Stage 7: rebuild the worst component, odd-q row, saturate. Its
    // output register parts the result channel from the rest.
    pth_pick u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cube_valid),
        .in_ready  (cube_ready),
        .in_data   (cube_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // Rounded cube coordinates never stray more than one from summing to zero.
    assign cube_sum = (INT_W+2)'(cube_data.q) + (INT_W+2)'(cube_data.r)
                    + (INT_W+2)'(cube_data.s);

    // Input only backs up when every stage holds an item and the output waits.
    `ASSERT_IMPLIES(a_stall_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready)
    `ASSERT_IMPLIES(a_cube_sum, aclk, aresetn, cube_valid, cube_sum == 0 || cube_sum == 1 || cube_sum == -1)
    `ASSERT_NEXT(a_cfg_write, aclk, aresetn, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SIZE_RECIP), size_recip == $past(pwdata[RECIP_W-1:0]))

endmodule

// ===== rtl/pth_cfg.sv =====
// APB-style register file holding the reciprocal of the hexagon size.
// Depends on pth_pkg.
module pth_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pth_pkg::ADDR_W-1:0]  paddr,
    input  logic [pth_pkg::APB_DW-1:0]  pwdata,
    output logic [pth_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [pth_pkg::RECIP_W-1:0] size_recip
);
    import pth_pkg::*;

    logic [RECIP_W-1:0]   size_recip_reg;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_recip_reg <= RECIP_RESET;
        end else if (wr_en && (reg_index == REG_SIZE_RECIP)) begin
            size_recip_reg <= pwdata[RECIP_W-1:0];
        end
    end

    assign prdata     = (reg_index == REG_SIZE_RECIP) ? APB_DW'(size_recip_reg) : '0;
    assign size_recip = size_recip_reg;

endmodule

// ===== rtl/pth_mult.sv =====
// Two multiply stages: scale the pixel pair, then form the Q.46 products.
// Depends on pth_pkg.
module pth_mult (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pth_pkg::RECIP_W-1:0] size_recip,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pth_pkg::pixel_t             in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pth_pkg::prod_t              out_data
);
    import pth_pkg::*;

    logic                      a_valid_reg;
    logic                      b_valid_reg;
    logic signed [SCALE_W-1:0] sx_reg;
    logic signed [SCALE_W-1:0] sy_reg;
    prod_t                     prod_reg;

    logic                      a_ready;
    logic                      b_ready;
    logic signed [SCALE_W-1:0] recip_ext;
    logic signed [SCALE_W-1:0] sx_next;
    logic signed [SCALE_W-1:0] sy_next;
    logic signed [PROD_W-1:0]  sx_wide;
    logic signed [PROD_W-1:0]  sy_wide;
    prod_t                     prod_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        recip_ext      = $signed(SCALE_W'(size_recip));
        sx_next        = SCALE_W'(in_data.pixel_x) * recip_ext;
        sy_next        = SCALE_W'(in_data.pixel_y) * recip_ext;
        sx_wide        = PROD_W'(sx_reg);
        sy_wide        = PROD_W'(sy_reg);
        prod_next.pq   = sx_wide * PROD_W'(K_TWO_THIRDS);
        prod_next.pa   = sy_wide * PROD_W'(K_ROOT3_THIRD);
        prod_next.pb   = sx_wide * PROD_W'(K_ONE_THIRD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (b_ready && a_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = prod_reg;

endmodule

// ===== rtl/pth_frac.sv =====
// Two stages: reduce the products to fractional axial q, r, then form s.
// Depends on pth_pkg.
module pth_frac (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pth_pkg::prod_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pth_pkg::frac_t out_data
);
    import pth_pkg::*;

    logic                 c_valid_reg;
    logic                 d_valid_reg;
    logic signed [FW-1:0] fq_reg;
    logic signed [FW-1:0] fr_reg;
    frac_t                frac_reg;

    logic                 c_ready;
    logic                 d_ready;
    logic signed [FW-1:0] fq_next;
    logic signed [FW-1:0] fr_next;
    frac_t                frac_next;

    // Round to nearest, ties toward plus infinity.
    function automatic logic signed [FW-1:0] reduce_prod(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] t;
        t = (v + RED_HALF) >>> RED_SHIFT;
        return FW'(t);
    endfunction

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb begin
        fq_next      = reduce_prod(DIFF_W'(in_data.pq));
        fr_next      = reduce_prod(DIFF_W'(in_data.pa) - DIFF_W'(in_data.pb));
        frac_next.fq = fq_reg;
        frac_next.fr = fr_reg;
        frac_next.fs = -fq_reg - fr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            fq_reg <= fq_next;
            fr_reg <= fr_next;
        end
        if (d_ready && c_valid_reg) begin
            frac_reg <= frac_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = frac_reg;

endmodule

// ===== rtl/pth_round.sv =====
// Two stages: round q, r, s away from zero, then take the rounding errors.
// Depends on pth_pkg.
module pth_round (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pth_pkg::frac_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pth_pkg::cube_t out_data
);
    import pth_pkg::*;

    logic                    e_valid_reg;
    logic                    f_valid_reg;
    logic signed [INT_W-1:0] q_reg;
    logic signed [INT_W-1:0] r_reg;
    logic signed [INT_W-1:0] s_reg;
    frac_t                   frac_reg;
    cube_t                   cube_reg;

    logic                    e_ready;
    logic                    f_ready;
    cube_t                   cube_next;

    function automatic logic signed [INT_W-1:0] round_away(input logic signed [FW-1:0] v);
        logic [FW-1:0] mag;
        logic [FW-1:0] n;
        mag = v[FW-1] ? -v : v;
        n   = (mag + RND_HALF) >> FRAC_BITS;
        return v[FW-1] ? -$signed(INT_W'(n)) : $signed(INT_W'(n));
    endfunction

    function automatic logic [FRAC_BITS-1:0] round_err(input logic signed [INT_W-1:0] n,
                                                       input logic signed [FW-1:0] v);
        logic signed [EW-1:0] d;
        d = (EW'(n) <<< FRAC_BITS) - EW'(v);
        return d[EW-1] ? FRAC_BITS'(-d) : FRAC_BITS'(d);
    endfunction

    assign f_ready  = !f_valid_reg || out_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    always_comb begin
        cube_next.q  = q_reg;
        cube_next.r  = r_reg;
        cube_next.s  = s_reg;
        cube_next.dq = round_err(q_reg, frac_reg.fq);
        cube_next.dr = round_err(r_reg, frac_reg.fr);
        cube_next.ds = round_err(s_reg, frac_reg.fs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (e_ready) begin
                e_valid_reg <= in_valid;
            end
            if (f_ready) begin
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && in_valid) begin
            q_reg    <= round_away(in_data.fq);
            r_reg    <= round_away(in_data.fr);
            s_reg    <= round_away(in_data.fs);
            frac_reg <= in_data;
        end
        if (f_ready && e_valid_reg) begin
            cube_reg <= cube_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = cube_reg;

endmodule

// ===== rtl/pth_pick.sv =====
// Output stage: rebuild the component with the largest error, form the
// odd-q offset row, saturate and hold the result. Depends on pth_pkg.
module pth_pick (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pth_pkg::cube_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pth_pkg::hex_t  out_data
);
    import pth_pkg::*;

    logic                    out_valid_reg;
    hex_t                    hex_reg;

    logic                    g_ready;
    logic signed [INT_W-1:0] q_fix;
    logic signed [INT_W-1:0] r_fix;
    logic signed [ROW_W-1:0] row;
    hex_t                    hex_next;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ROW_W-1:0] v);
        logic signed [ROW_W-1:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return OUT_W'(c);
    endfunction

    assign g_ready  = !out_valid_reg || out_ready;
    assign in_ready = g_ready;

    always_comb begin
        q_fix = in_data.q;
        r_fix = in_data.r;
        if ((in_data.dq > in_data.dr) && (in_data.dq > in_data.ds)) begin
            q_fix = -in_data.r - in_data.s;
        end else if (in_data.dr > in_data.ds) begin
            r_fix = -in_data.q - in_data.s;
        end
        // (q - parity) / 2 is the floor of q / 2
        row = ROW_W'(r_fix) + ROW_W'(q_fix >>> 1);
        hex_next.axial_q    = sat_out(ROW_W'(q_fix));
        hex_next.axial_r    = sat_out(ROW_W'(r_fix));
        hex_next.offset_col = sat_out(ROW_W'(q_fix));
        hex_next.offset_row = sat_out(row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (g_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (g_ready && in_valid) begin
            hex_reg <= hex_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = hex_reg;

endmodule
